// ===== hw/rtl/paired_sample_statistics_unit_assert.svh =====
// assertion macros for the checker file of the statistics unit
// depends on: a clock named clk and an active-low reset named rst_n in scope
`ifndef PAIRED_SAMPLE_STATISTICS_UNIT_ASSERT_SVH
`define PAIRED_SAMPLE_STATISTICS_UNIT_ASSERT_SVH

// same-cycle implication
`define PSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pss_pkg.sv =====
// shared constants, codes and control structs of the statistics unit
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

    localparam int PSS_MAX_SAMPLES = 1024;
    localparam int ADDR_W = $clog2(PSS_MAX_SAMPLES);
    localparam int CNT_W = $clog2(PSS_MAX_SAMPLES + 1);
    localparam int SMP_W = 16;
    localparam int FREE_W = 10;
    localparam int CMP_W = (CNT_W > FREE_W) ? CNT_W : FREE_W;
    localparam int SUM_W = SMP_W + CNT_W;
    localparam int CD_W = CNT_W + SMP_W + 1;
    localparam int PR_W = SMP_W + CD_W;
    localparam int DEV_W = 56;
    localparam int DIV_W = 68;
    localparam int MAG_W = DIV_W - 16;
    localparam int DEN_W = 2 * CNT_W;
    localparam int MEAN_W = 24;
    localparam int VAR_W = 49;
    localparam int COV_W = 50;
    localparam int STD_W = 24;
    localparam int SQ_IT = (VAR_W + 1) / 2;
    localparam int RM_W = SQ_IT + 4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

    typedef enum logic [2:0] {
        SEL_MEAN_A,
        SEL_MEAN_B,
        SEL_VAR_A,
        SEL_VAR_B,
        SEL_COV
    } pss_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        pss_sel_t div_sel;
        logic     pass_start;
        logic     sqrt_start;
        logic     sqrt_b;
        logic     publish;
    } pss_cmd_t;

    typedef struct packed {
        logic div_done;
        logic pass_done;
        logic sqrt_done;
        logic too_few;
        logic out_free;
    } pss_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pss_div.sv =====
// iterative restoring divider, one quotient bit per cycle, with round-half flag
// depends on: pss_pkg
`timescale 1ns / 1ps
`default_nettype none

module pss_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [pss_pkg::DIV_W-1:0]  num,
    input  wire logic [pss_pkg::DEN_W-1:0]  den,
    output logic                            done,
    output logic [pss_pkg::DIV_W-1:0]       quot,
    output logic                            round_up
);
    import pss_pkg::*;

    localparam int IT_W = $clog2(DIV_W);

    logic              busy_reg;
    logic              done_reg;
    logic [IT_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]  nq_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    rem_sh;
    logic              ge;
    logic [DEN_W-1:0]  rem_next;
    logic [DIV_W-1:0]  nq_next;

    always_comb
    begin
        rem_sh = {rem_reg, nq_reg[DIV_W-1]};
        ge = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
        nq_next = {nq_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= IT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            nq_reg <= nq_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = nq_reg;
    // remainder at least half the divisor
    assign round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/pss_ctrl.sv =====
// sequencer of the statistics unit: load, means, second pass, divisions, roots
// depends on: pss_pkg
`timescale 1ns / 1ps
`default_nettype none

module pss_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                last,
    input  wire pss_pkg::pss_stat_t  stat,
    output logic                     in_stall,
    output pss_pkg::pss_cmd_t        cmd
);
    import pss_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_MEAN_A,
        S_MEAN_B,
        S_PASS,
        S_VAR_A,
        S_VAR_B,
        S_COV,
        S_SQRT_A,
        S_SQRT_B,
        S_WAIT_OUT
    } state_t;

    state_t   state_reg;
    logic     div_start_reg;
    pss_sel_t div_sel_reg;
    logic     pass_start_reg;
    logic     sqrt_start_reg;
    logic     sqrt_b_reg;
    logic     load;
    logic     publish;

    assign load = in_valid && (state_reg == S_LOAD);
    assign publish = (state_reg == S_WAIT_OUT) && stat.out_free;
    assign in_stall = (state_reg != S_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            div_start_reg <= 1'b0;
            div_sel_reg <= SEL_MEAN_A;
            pass_start_reg <= 1'b0;
            sqrt_start_reg <= 1'b0;
            sqrt_b_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            pass_start_reg <= 1'b0;
            sqrt_start_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                begin
                    if (load && last)
                    begin
                        state_reg <= S_MEAN_A;
                        div_start_reg <= 1'b1;
                        div_sel_reg <= SEL_MEAN_A;
                    end
                end
                S_MEAN_A:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_MEAN_B;
                        div_start_reg <= 1'b1;
                        div_sel_reg <= SEL_MEAN_B;
                    end
                end
                S_MEAN_B:
                begin
                    if (stat.div_done)
                    begin
                        if (stat.too_few)
                        begin
                            state_reg <= S_WAIT_OUT;
                        end
                        else
                        begin
                            state_reg <= S_PASS;
                            pass_start_reg <= 1'b1;
                        end
                    end
                end
                S_PASS:
                begin
                    if (stat.pass_done)
                    begin
                        state_reg <= S_VAR_A;
                        div_start_reg <= 1'b1;
                        div_sel_reg <= SEL_VAR_A;
                    end
                end
                S_VAR_A:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_VAR_B;
                        div_start_reg <= 1'b1;
                        div_sel_reg <= SEL_VAR_B;
                    end
                end
                S_VAR_B:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_COV;
                        div_start_reg <= 1'b1;
                        div_sel_reg <= SEL_COV;
                    end
                end
                S_COV:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_SQRT_A;
                        sqrt_start_reg <= 1'b1;
                        sqrt_b_reg <= 1'b0;
                    end
                end
                S_SQRT_A:
                begin
                    if (stat.sqrt_done)
                    begin
                        state_reg <= S_SQRT_B;
                        sqrt_start_reg <= 1'b1;
                        sqrt_b_reg <= 1'b1;
                    end
                end
                S_SQRT_B:
                begin
                    if (stat.sqrt_done)
                    begin
                        state_reg <= S_WAIT_OUT;
                    end
                end
                S_WAIT_OUT:
                begin
                    if (publish)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.load = load;
        cmd.div_start = div_start_reg;
        cmd.div_sel = div_sel_reg;
        cmd.pass_start = pass_start_reg;
        cmd.sqrt_start = sqrt_start_reg;
        cmd.sqrt_b = sqrt_b_reg;
        cmd.publish = publish;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pss_dp.sv =====
// datapath: sample stores, running sums, deviation pass, root unit, result registers
// depends on: pss_pkg; drives the shared divider pss_div
`timescale 1ns / 1ps
`default_nettype none

module pss_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire pss_pkg::pss_cmd_t                    cmd,
    output pss_pkg::pss_stat_t                        stat,
    input  wire logic                                 cfg_write,
    input  wire logic [pss_pkg::FREE_W-1:0]           cfg_data,
    input  wire logic signed [pss_pkg::SMP_W-1:0]     sample_a,
    input  wire logic signed [pss_pkg::SMP_W-1:0]     sample_b,
    input  wire logic                                 out_stall,
    output logic                                      div_start,
    output logic [pss_pkg::DIV_W-1:0]                 div_num,
    output logic [pss_pkg::DEN_W-1:0]                 div_den,
    input  wire logic                                 div_done,
    input  wire logic [pss_pkg::DIV_W-1:0]            div_quot,
    input  wire logic                                 div_round,
    output logic                                      out_valid,
    output logic signed [pss_pkg::MEAN_W-1:0]         mean_a,
    output logic signed [pss_pkg::MEAN_W-1:0]         mean_b,
    output logic [pss_pkg::VAR_W-1:0]                 var_a,
    output logic [pss_pkg::VAR_W-1:0]                 var_b,
    output logic [pss_pkg::STD_W-1:0]                 std_a,
    output logic [pss_pkg::STD_W-1:0]                 std_b,
    output logic signed [pss_pkg::COV_W-1:0]          cov_ab,
    output logic [1:0]                                status
);
    import pss_pkg::*;

    localparam int SQ_CW = $clog2(SQ_IT);

    // batch state
    logic [FREE_W-1:0]        freedom_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [SUM_W-1:0]  sum_a_reg;
    logic signed [SUM_W-1:0]  sum_b_reg;
    logic                     drop_reg;
    logic                     full;
    logic [SMP_W-1:0]         mem_a [PSS_MAX_SAMPLES];
    logic [SMP_W-1:0]         mem_b [PSS_MAX_SAMPLES];

    // deviation pass
    logic                     run_reg;
    logic                     iss_reg;
    logic                     rv_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic signed [SMP_W-1:0]  rd_a_reg;
    logic signed [SMP_W-1:0]  rd_b_reg;
    logic signed [SMP_W-1:0]  xa1_reg;
    logic signed [SMP_W-1:0]  xb1_reg;
    logic signed [CD_W-1:0]   ca1_reg;
    logic signed [CD_W-1:0]   cb1_reg;
    logic signed [CD_W-1:0]   ca_c;
    logic signed [CD_W-1:0]   cb_c;
    logic signed [PR_W-1:0]   pa_reg;
    logic signed [PR_W-1:0]   pb_reg;
    logic signed [PR_W-1:0]   pab_reg;
    logic signed [DEV_W-1:0]  dev_a_reg;
    logic signed [DEV_W-1:0]  dev_b_reg;
    logic signed [DEV_W-1:0]  dev_ab_reg;
    logic                     pass_done;
    logic [DEN_W-1:0]         den_reg;
    logic [CNT_W-1:0]         n_minus_f;

    // division bookkeeping
    pss_sel_t                 sel_reg;
    logic                     neg_reg;
    logic [SUM_W-1:0]         mag_sa;
    logic [SUM_W-1:0]         mag_sb;
    logic [DEV_W-1:0]         mag_da;
    logic [DEV_W-1:0]         mag_db;
    logic [DEV_W-1:0]         mag_dab;
    logic [DIV_W:0]           qr;
    logic [DIV_W:0]           lim_pos;
    logic [DIV_W:0]           lim_neg;
    logic [VAR_W-1:0]         var_sat;
    logic [COV_W-1:0]         cov_pos;
    logic [COV_W-1:0]         cov_mag;

    // root unit
    logic                     sq_busy_reg;
    logic                     sq_done_reg;
    logic                     sq_b_reg;
    logic [SQ_CW-1:0]         sq_cnt_reg;
    logic [2*SQ_IT-1:0]       sq_v_reg;
    logic [RM_W-1:0]          sq_rem_reg;
    logic [SQ_IT-1:0]         sq_root_reg;
    logic [RM_W-1:0]          sq_rem_sh;
    logic [RM_W-1:0]          sq_trial;
    logic                     sq_ge;
    logic [SQ_IT-1:0]         sq_root_next;
    logic [STD_W-1:0]         sq_std;

    // working results
    logic [MEAN_W-1:0]        mean_a_w;
    logic [MEAN_W-1:0]        mean_b_w;
    logic [VAR_W-1:0]         var_a_w;
    logic [VAR_W-1:0]         var_b_w;
    logic [STD_W-1:0]         std_a_w;
    logic [STD_W-1:0]         std_b_w;
    logic [COV_W-1:0]         cov_w;
    logic                     too_few;

    // output word
    logic                     out_valid_reg;
    logic [MEAN_W-1:0]        mean_a_reg;
    logic [MEAN_W-1:0]        mean_b_reg;
    logic [VAR_W-1:0]         var_a_reg;
    logic [VAR_W-1:0]         var_b_reg;
    logic [STD_W-1:0]         std_a_reg;
    logic [STD_W-1:0]         std_b_reg;
    logic [COV_W-1:0]         cov_reg;
    logic [1:0]               status_reg;

    assign full = (count_reg == CNT_W'(PSS_MAX_SAMPLES));
    assign too_few = (CMP_W'(count_reg) <= CMP_W'(freedom_reg));
    assign n_minus_f = CNT_W'(CMP_W'(count_reg) - CMP_W'(freedom_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freedom_reg <= '0;
            count_reg <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                freedom_reg <= cfg_data;
            end
            if (cmd.publish)
            begin
                count_reg <= '0;
                sum_a_reg <= '0;
                sum_b_reg <= '0;
                drop_reg <= 1'b0;
            end
            else if (cmd.load)
            begin
                if (full)
                begin
                    drop_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_a_reg <= sum_a_reg + SUM_W'(sample_a);
                    sum_b_reg <= sum_b_reg + SUM_W'(sample_b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            mem_a[count_reg[ADDR_W-1:0]] <= sample_a;
            mem_b[count_reg[ADDR_W-1:0]] <= sample_b;
        end
        rd_a_reg <= mem_a[idx_reg[ADDR_W-1:0]];
        rd_b_reg <= mem_b[idx_reg[ADDR_W-1:0]];
    end

    // pass control
    assign pass_done = run_reg && !iss_reg && !rv_reg && !v1_reg && !v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            iss_reg <= 1'b0;
            rv_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            rv_reg <= iss_reg;
            v1_reg <= rv_reg;
            v2_reg <= v1_reg;
            if (cmd.pass_start)
            begin
                run_reg <= 1'b1;
                iss_reg <= 1'b1;
                idx_reg <= '0;
            end
            else
            begin
                if (pass_done)
                begin
                    run_reg <= 1'b0;
                end
                if (iss_reg)
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == count_reg - 1'b1)
                    begin
                        iss_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // centered terms: n * x - sum
    always_comb
    begin
        ca_c = CD_W'($signed({1'b0, count_reg}) * rd_a_reg) - CD_W'(sum_a_reg);
        cb_c = CD_W'($signed({1'b0, count_reg}) * rd_b_reg) - CD_W'(sum_b_reg);
    end

    always_ff @(posedge clk)
    begin
        xa1_reg <= rd_a_reg;
        xb1_reg <= rd_b_reg;
        ca1_reg <= ca_c;
        cb1_reg <= cb_c;
        pa_reg <= PR_W'(xa1_reg * ca1_reg);
        pb_reg <= PR_W'(xb1_reg * cb1_reg);
        pab_reg <= PR_W'(xa1_reg * cb1_reg);
        if (cmd.pass_start)
        begin
            dev_a_reg <= '0;
            dev_b_reg <= '0;
            dev_ab_reg <= '0;
            den_reg <= DEN_W'(count_reg * n_minus_f);
        end
        else if (v2_reg)
        begin
            dev_a_reg <= dev_a_reg + DEV_W'(pa_reg);
            dev_b_reg <= dev_b_reg + DEV_W'(pb_reg);
            dev_ab_reg <= dev_ab_reg + DEV_W'(pab_reg);
        end
    end

    // divider operands
    always_comb
    begin
        mag_sa = sum_a_reg[SUM_W-1] ? SUM_W'(-sum_a_reg) : SUM_W'(sum_a_reg);
        mag_sb = sum_b_reg[SUM_W-1] ? SUM_W'(-sum_b_reg) : SUM_W'(sum_b_reg);
        mag_da = dev_a_reg[DEV_W-1] ? DEV_W'(-dev_a_reg) : DEV_W'(dev_a_reg);
        mag_db = dev_b_reg[DEV_W-1] ? DEV_W'(-dev_b_reg) : DEV_W'(dev_b_reg);
        mag_dab = dev_ab_reg[DEV_W-1] ? DEV_W'(-dev_ab_reg) : DEV_W'(dev_ab_reg);
        div_den = den_reg;
        case (cmd.div_sel)
            SEL_MEAN_A:
            begin
                div_num = DIV_W'({mag_sa, 8'd0});
                div_den = DEN_W'(count_reg);
            end
            SEL_MEAN_B:
            begin
                div_num = DIV_W'({mag_sb, 8'd0});
                div_den = DEN_W'(count_reg);
            end
            SEL_VAR_A: div_num = {mag_da[MAG_W-1:0], 16'd0};
            SEL_VAR_B: div_num = {mag_db[MAG_W-1:0], 16'd0};
            SEL_COV:   div_num = {mag_dab[MAG_W-1:0], 16'd0};
            default:   div_num = '0;
        endcase
    end

    assign div_start = cmd.div_start;

    always_comb
    begin
        qr = {1'b0, div_quot} + (DIV_W + 1)'(div_round);
        lim_pos = (DIV_W + 1)'({VAR_W{1'b1}});
        lim_neg = (DIV_W + 1)'(1) << VAR_W;
        var_sat = (qr > lim_pos) ? {VAR_W{1'b1}} : qr[VAR_W-1:0];
        cov_pos = COV_W'(var_sat);
        cov_mag = (qr > lim_neg) ? lim_neg[COV_W-1:0] : qr[COV_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            sel_reg <= cmd.div_sel;
            case (cmd.div_sel)
                SEL_MEAN_A: neg_reg <= sum_a_reg[SUM_W-1];
                SEL_MEAN_B: neg_reg <= sum_b_reg[SUM_W-1];
                SEL_COV:    neg_reg <= dev_ab_reg[DEV_W-1];
                default:    neg_reg <= 1'b0;
            endcase
        end
        if (div_done)
        begin
            case (sel_reg)
                SEL_MEAN_A: mean_a_w <= neg_reg ? MEAN_W'(-qr[MEAN_W-1:0]) : qr[MEAN_W-1:0];
                SEL_MEAN_B: mean_b_w <= neg_reg ? MEAN_W'(-qr[MEAN_W-1:0]) : qr[MEAN_W-1:0];
                SEL_VAR_A:  var_a_w <= var_sat;
                SEL_VAR_B:  var_b_w <= var_sat;
                SEL_COV:    cov_w <= neg_reg ? COV_W'(-cov_mag) : cov_pos;
                default:    cov_w <= cov_w;
            endcase
        end
    end

    // digit-by-digit square root, two radicand bits per cycle
    always_comb
    begin
        sq_rem_sh = {sq_rem_reg[RM_W-3:0], sq_v_reg[2*SQ_IT-1 -: 2]};
        sq_trial = RM_W'({sq_root_reg, 2'b01});
        sq_ge = sq_rem_sh >= sq_trial;
        sq_root_next = {sq_root_reg[SQ_IT-2:0], sq_ge};
        sq_std = (sq_root_next > SQ_IT'({STD_W{1'b1}})) ? {STD_W{1'b1}}
                                                         : sq_root_next[STD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            sq_cnt_reg <= '0;
        end
        else
        begin
            sq_done_reg <= 1'b0;
            if (cmd.sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg <= SQ_CW'(SQ_IT - 1);
            end
            else if (sq_busy_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg - 1'b1;
                if (sq_cnt_reg == '0)
                begin
                    sq_busy_reg <= 1'b0;
                    sq_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sq_b_reg <= cmd.sqrt_b;
            sq_v_reg <= (2 * SQ_IT)'(cmd.sqrt_b ? var_b_w : var_a_w);
            sq_rem_reg <= '0;
            sq_root_reg <= '0;
        end
        else if (sq_busy_reg)
        begin
            sq_v_reg <= {sq_v_reg[2*SQ_IT-3:0], 2'b00};
            sq_rem_reg <= sq_ge ? RM_W'(sq_rem_sh - sq_trial) : sq_rem_sh;
            sq_root_reg <= sq_root_next;
            if (sq_cnt_reg == '0)
            begin
                if (sq_b_reg)
                begin
                    std_b_w <= sq_std;
                end
                else
                begin
                    std_a_w <= sq_std;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            mean_a_reg <= mean_a_w;
            mean_b_reg <= mean_b_w;
            var_a_reg <= too_few ? '0 : var_a_w;
            var_b_reg <= too_few ? '0 : var_b_w;
            std_a_reg <= too_few ? '0 : std_a_w;
            std_b_reg <= too_few ? '0 : std_b_w;
            cov_reg <= too_few ? '0 : cov_w;
            status_reg <= too_few ? ST_FEW : (drop_reg ? ST_DROP : ST_OK);
        end
    end

    always_comb
    begin
        stat.div_done = div_done;
        stat.pass_done = pass_done;
        stat.sqrt_done = sq_done_reg;
        stat.too_few = too_few;
        stat.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign mean_a = mean_a_reg;
    assign mean_b = mean_b_reg;
    assign var_a = var_a_reg;
    assign var_b = var_b_reg;
    assign std_a = std_a_reg;
    assign std_b = std_b_reg;
    assign cov_ab = cov_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/paired_sample_statistics_unit.sv =====
// samples load one word per cycle while loading; after the last word the shared divider forms
// both means, then the deviation pass, three more divisions and two roots run in turn
// throughput: one sample word per cycle while loading; the batch end is set by the
// one-bit-per-cycle divider and the one-entry-per-cycle store read in the second pass
// reset: asynchronous active low; clears count, sums, drop flag, freedom and control;
// sample stores are not cleared
`timescale 1ns / 1ps
`default_nettype none

module paired_sample_statistics_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration: degrees of freedom
    input  wire logic                                 cfg_write,
    input  wire logic [pss_pkg::FREE_W-1:0]           cfg_data,
    // input word
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [pss_pkg::SMP_W-1:0]     sample_a,
    input  wire logic signed [pss_pkg::SMP_W-1:0]     sample_b,
    input  wire logic                                 last,
    // result word
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [pss_pkg::MEAN_W-1:0]         mean_a,
    output logic signed [pss_pkg::MEAN_W-1:0]         mean_b,
    output logic [pss_pkg::VAR_W-1:0]                 var_a,
    output logic [pss_pkg::VAR_W-1:0]                 var_b,
    output logic [pss_pkg::STD_W-1:0]                 std_a,
    output logic [pss_pkg::STD_W-1:0]                 std_b,
    output logic signed [pss_pkg::COV_W-1:0]          cov_ab,
    output logic [1:0]                                status
);
    import pss_pkg::*;

    pss_cmd_t           cmd;
    pss_stat_t          stat;
    logic               div_start;
    logic [DIV_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;
    logic               div_round;

    // sequencer: accepts words in the load state, then walks the batch computation
    pss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // stores, sums, deviation pass, root unit and the result word register
    pss_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .sample_a  (sample_a),
        .sample_b  (sample_b),
        .out_stall (out_stall),
        .div_start (div_start),
        .div_num   (div_num),
        .div_den   (div_den),
        .div_done  (div_done),
        .div_quot  (div_quot),
        .div_round (div_round),
        .out_valid (out_valid),
        .mean_a    (mean_a),
        .mean_b    (mean_b),
        .var_a     (var_a),
        .var_b     (var_b),
        .std_a     (std_a),
        .std_b     (std_b),
        .cov_ab    (cov_ab),
        .status    (status)
    );

    // one divider shared by both means, both variances and the covariance
    pss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quot     (div_quot),
        .round_up (div_round)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/pss_checker.sv =====
// port-level checks of the statistics unit, bound to the top level
// depends on: pss_pkg, paired_sample_statistics_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "paired_sample_statistics_unit_assert.svh"

module pss_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_valid,
    input wire logic                                 in_stall,
    input wire logic                                 last,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic signed [pss_pkg::MEAN_W-1:0]    mean_a,
    input wire logic [pss_pkg::VAR_W-1:0]            var_a,
    input wire logic [pss_pkg::VAR_W-1:0]            var_b,
    input wire logic [pss_pkg::STD_W-1:0]            std_a,
    input wire logic [pss_pkg::STD_W-1:0]            std_b,
    input wire logic signed [pss_pkg::COV_W-1:0]     cov_ab,
    input wire logic [1:0]                           status
);
    import pss_pkg::*;

    logic [2*STD_W-1:0] std_a_sq;

    always_comb
    begin
        std_a_sq = {{STD_W{1'b0}}, std_a} * {{STD_W{1'b0}}, std_a};
    end

    `PSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(mean_a) && $stable(var_a) && $stable(status),
        "stalled result word changed")
    `PSS_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && last, in_stall,
        "input not stalled after last word")
    `PSS_ASSERT_NOW(a_few_zero, out_valid && status == ST_FEW,
        var_a == '0 && var_b == '0 && std_a == '0 && std_b == '0 && cov_ab == '0,
        "nonzero spread with too few samples")
    `PSS_ASSERT_NOW(a_std_floor, out_valid, VAR_W'(std_a_sq) <= var_a,
        "std_a squared exceeds var_a")

endmodule

bind paired_sample_statistics_unit pss_checker u_pss_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking bench for paired_sample_statistics_unit: directed table, an overfull batch, then random batches
// depends on: pss_pkg and the paired_sample_statistics_unit rtl
`timescale 1ns / 1ps

module tb;
    import pss_pkg::*;

    localparam int CLK_HALF = 2;
    localparam int SETTLE_CYCLES = 16;     // quiet time before a freedom write
    localparam int DRAIN_CYCLES = 1500;
    localparam int RAND_ITEMS = 800;
    localparam longint unsigned LIM49 = (64'd1 << 49) - 1;
    localparam longint unsigned LIM24 = (64'd1 << 24) - 1;
    localparam int NO_CFG = -1;

    // one result word, as the block presents it
    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_a;
        logic signed [MEAN_W-1:0] mean_b;
        logic [VAR_W-1:0]         var_a;
        logic [VAR_W-1:0]         var_b;
        logic [STD_W-1:0]         std_a;
        logic [STD_W-1:0]         std_b;
        logic signed [COV_W-1:0]  cov_ab;
        logic [1:0]               status;
    } stats_t;

    // directed row: optional freedom write before it, one pair, optional typed result
    typedef struct {
        int                       cfg;
        logic signed [SMP_W-1:0]  a;
        logic signed [SMP_W-1:0]  b;
        logic                     last;
        bit                       typed;
        stats_t                   res;
    } row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [FREE_W-1:0]         cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [SMP_W-1:0]   sample_a;
    logic signed [SMP_W-1:0]   sample_b;
    logic                      last;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [MEAN_W-1:0]  mean_a;
    logic signed [MEAN_W-1:0]  mean_b;
    logic [VAR_W-1:0]          var_a;
    logic [VAR_W-1:0]          var_b;
    logic [STD_W-1:0]          std_a;
    logic [STD_W-1:0]          std_b;
    logic signed [COV_W-1:0]   cov_ab;
    logic [1:0]                status;

    paired_sample_statistics_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample_a  (sample_a),
        .sample_b  (sample_b),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mean_a    (mean_a),
        .mean_b    (mean_b),
        .var_a     (var_a),
        .var_b     (var_b),
        .std_a     (std_a),
        .std_b     (std_b),
        .cov_ab    (cov_ab),
        .status    (status)
    );

    // model of the batch state
    logic signed [SMP_W-1:0] held_a [PSS_MAX_SAMPLES];
    logic signed [SMP_W-1:0] held_b [PSS_MAX_SAMPLES];
    int                      held_n;
    longint                  run_sum_a;
    longint                  run_sum_b;
    bit                      lost_pair;
    int                      dof;

    stats_t                  stats_q [$];
    int                      errors;
    bit                      calm;        // no idling on either side while set

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // hard limit on the whole run
    initial
    begin
        #10000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // round(256 * s / n), ties away from zero
    function automatic logic [MEAN_W-1:0] q8_mean(input longint s, input longint unsigned n);
        longint unsigned m;
        longint unsigned q;
        m = (s < 0 ? -s : s) << 8;
        q = m / n;
        if (2 * (m % n) >= n)
            q++;
        if (s < 0)
            q = -q;
        return q[MEAN_W-1:0];
    endfunction

    // round(65536 * mag / den), saturated at lim
    function automatic longint unsigned q16_div(input longint unsigned mag,
                                                input longint unsigned den,
                                                input longint unsigned lim);
        longint unsigned q;
        longint unsigned r2;
        longint unsigned f;
        longint unsigned res;
        q = mag / den;
        if (q > (lim >> 16))
            return lim;
        r2 = (mag % den) << 16;
        f = r2 / den;
        if (2 * (r2 % den) >= den)
            f++;
        res = (q << 16) + f;
        return (res > lim) ? lim : res;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return (res > LIM24) ? LIM24 : res;
    endfunction

    // absorb one pair; on the closing pair compute the batch statistics
    function automatic bit absorb_pair(input logic signed [SMP_W-1:0] a,
                                       input logic signed [SMP_W-1:0] b,
                                       input logic fin, output stats_t r);
        longint unsigned n;
        longint unsigned den;
        longint dev_a;
        longint dev_b;
        longint dev_ab;
        longint ca;
        longint cb;
        longint unsigned cv;
        if (held_n < PSS_MAX_SAMPLES)
        begin
            held_a[held_n] = a;
            held_b[held_n] = b;
            held_n++;
            run_sum_a += a;
            run_sum_b += b;
        end
        else
            lost_pair = 1'b1;
        r = '0;
        if (!fin)
            return 1'b0;
        n = held_n;
        r.mean_a = q8_mean(run_sum_a, n);
        r.mean_b = q8_mean(run_sum_b, n);
        r.status = lost_pair ? ST_DROP : ST_OK;
        if (n <= dof)
            r.status = ST_FEW;
        else
        begin
            // second pass: n times the deviation sums, exact
            den = n * (n - dof);
            dev_a = 0;
            dev_b = 0;
            dev_ab = 0;
            for (int i = 0; i < held_n; i++)
            begin
                ca = longint'(n) * held_a[i] - run_sum_a;
                cb = longint'(n) * held_b[i] - run_sum_b;
                dev_a += held_a[i] * ca;
                dev_b += held_b[i] * cb;
                dev_ab += held_a[i] * cb;
            end
            r.var_a = VAR_W'(q16_div(dev_a < 0 ? -dev_a : dev_a, den, LIM49));
            r.var_b = VAR_W'(q16_div(dev_b < 0 ? -dev_b : dev_b, den, LIM49));
            r.std_a = STD_W'(floor_root(r.var_a));
            r.std_b = STD_W'(floor_root(r.var_b));
            if (dev_ab < 0)
                cv = -q16_div(-dev_ab, den, LIM49 + 1);
            else
                cv = q16_div(dev_ab, den, LIM49);
            r.cov_ab = cv[COV_W-1:0];
        end
        held_n = 0;
        run_sum_a = 0;
        run_sum_b = 0;
        lost_pair = 1'b0;
        return 1'b1;
    endfunction

    // present one word, wait for it to be taken, log what it should produce
    task automatic send_pair(input logic signed [SMP_W-1:0] a, input logic signed [SMP_W-1:0] b,
                             input logic fin, input bit typed, input stats_t typed_res);
        bit go;
        stats_t r;
        if (!calm && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_a <= a;
        sample_b <= b;
        last <= fin;
        // stall is stable from the falling edge up to the deciding rising edge
        do
        begin
            @(negedge clk);
            go = !in_stall;
            @(posedge clk);
        end
        while (!go);
        if (absorb_pair(a, b, fin, r))
            stats_q.push_back(typed ? typed_res : r);
    endtask

    // freedom is written only with the unit idle and nothing outstanding
    task automatic write_freedom(input logic [FREE_W-1:0] v);
        in_valid <= 1'b0;
        wait (stats_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        dof = int'(v);
    endtask

    function automatic logic signed [SMP_W-1:0] pick_sample();
        int mode;
        mode = $urandom_range(0, 7);
        if (mode == 0)
            return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if (mode < 4)
            return SMP_W'($signed($urandom_range(0, 600)) - 300);
        return SMP_W'($urandom());
    endfunction

    // random downstream stall
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 11);

    // result check, sampled at the falling edge ahead of the accepting edge
    always @(negedge clk)
    begin
        stats_t got;
        stats_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{mean_a, mean_b, var_a, var_b, std_a, std_b, cov_ab, status};
            if (stats_q.size() == 0)
            begin
                $display("%0t: unexpected result word %p", $time, got);
                errors++;
            end
            else
            begin
                want = stats_q.pop_front();
                if (got.mean_a !== want.mean_a)
                    $display("%0t: mean_a expected %0d got %0d", $time, want.mean_a, got.mean_a);
                if (got.mean_b !== want.mean_b)
                    $display("%0t: mean_b expected %0d got %0d", $time, want.mean_b, got.mean_b);
                if (got.var_a !== want.var_a)
                    $display("%0t: var_a expected %0d got %0d", $time, want.var_a, got.var_a);
                if (got.var_b !== want.var_b)
                    $display("%0t: var_b expected %0d got %0d", $time, want.var_b, got.var_b);
                if (got.std_a !== want.std_a)
                    $display("%0t: std_a expected %0d got %0d", $time, want.std_a, got.std_a);
                if (got.std_b !== want.std_b)
                    $display("%0t: std_b expected %0d got %0d", $time, want.std_b, got.std_b);
                if (got.cov_ab !== want.cov_ab)
                    $display("%0t: cov_ab expected %0d got %0d", $time, want.cov_ab, got.cov_ab);
                if (got.status !== want.status)
                    $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                if (got !== want)
                    errors++;
            end
        end
    end

    // directed rows; typed results are the ones readable by eye
    row_t plan [] = '{
        // single-pair batches at the extremes and near zero: mean is 256 * sample, spread is zero
        '{NO_CFG, 16'sh7fff, 16'sh7fff, 1'b1, 1'b1,
          '{24'sd8388352, 24'sd8388352, 0, 0, 0, 0, 0, ST_OK}},
        '{NO_CFG, 16'sh8000, 16'sh8000, 1'b1, 1'b1,
          '{-24'sd8388608, -24'sd8388608, 0, 0, 0, 0, 0, ST_OK}},
        '{NO_CFG, 16'sd0, 16'sd0, 1'b1, 1'b1, '{0, 0, 0, 0, 0, 0, 0, ST_OK}},
        '{NO_CFG, -16'sd1, 16'sd1, 1'b1, 1'b1,
          '{-24'sd256, 24'sd256, 0, 0, 0, 0, 0, ST_OK}},
        // opposite extremes, full swing, negative covariance
        '{NO_CFG, 16'sh7fff, 16'sh8000, 1'b0, 1'b0, '0},
        '{NO_CFG, 16'sh8000, 16'sh7fff, 1'b1, 1'b0, '0},
        // short ramp
        '{NO_CFG, 16'sd1, -16'sd5, 1'b0, 1'b0, '0},
        '{NO_CFG, 16'sd2, -16'sd3, 1'b0, 1'b0, '0},
        '{NO_CFG, 16'sd3, 16'sd7, 1'b0, 1'b0, '0},
        '{NO_CFG, 16'sd4, 16'sd11, 1'b1, 1'b0, '0},
        // count not above freedom: means only, status flags it
        '{3, 16'sd5, 16'sd5, 1'b1, 1'b1, '{24'sd1280, 24'sd1280, 0, 0, 0, 0, 0, ST_FEW}},
        '{NO_CFG, 16'sd10, -16'sd10, 1'b0, 1'b0, '0},
        '{NO_CFG, 16'sd20, -16'sd20, 1'b0, 1'b0, '0},
        '{NO_CFG, 16'sd30, -16'sd30, 1'b1, 1'b0, '0},
        // one above freedom: divisor of n
        '{NO_CFG, 16'sd100, 16'sd3, 1'b0, 1'b0, '0},
        '{NO_CFG, -16'sd100, 16'sd1, 1'b0, 1'b0, '0},
        '{NO_CFG, 16'sd7, -16'sd9, 1'b0, 1'b0, '0},
        '{NO_CFG, 16'sd0, 16'sh7fff, 1'b1, 1'b0, '0},
        // freedom one: sample variance
        '{1, 16'sd1, 16'sd2, 1'b0, 1'b0, '0},
        '{NO_CFG, 16'sd2, 16'sd2, 1'b0, 1'b0, '0},
        '{NO_CFG, 16'sd4, 16'sd3, 1'b1, 1'b0, '0},
        '{NO_CFG, 16'sd9, 16'sd9, 1'b1, 1'b1, '{24'sd2304, 24'sd2304, 0, 0, 0, 0, 0, ST_FEW}}
    };

    initial
    begin
        int len;
        int free_set [6] = '{0, 1, 2, 1023, 5, 0};
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_a = '0;
        sample_b = '0;
        last = 1'b0;
        out_stall = 1'b0;
        held_n = 0;
        run_sum_a = 0;
        run_sum_b = 0;
        lost_pair = 1'b0;
        dof = 0;
        errors = 0;
        calm = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].cfg != NO_CFG)
                write_freedom(FREE_W'(plan[i].cfg));
            send_pair(plan[i].a, plan[i].b, plan[i].last, plan[i].typed, plan[i].res);
        end

        // overfull batch of extremes, b the opposite extreme of a, freedom 1023: saturation and dropped pairs
        write_freedom(10'd1023);
        for (int i = 0; i < 1030; i++)
            send_pair(i[0] ? 16'sh7fff : 16'sh8000, i[0] ? 16'sh8000 : 16'sh7fff,
                      i == 1029, 1'b0, '0);

        // random batches under several freedom settings; one stretch with no idling
        for (int p = 0; p < 6; p++)
        begin
            write_freedom(FREE_W'(p == 4 ? $urandom_range(0, 20) : free_set[p]));
            calm = (p == 2);
            for (int k = 0; k < RAND_ITEMS / 6; k += len)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(1, 12);
                for (int j = 0; j < len; j++)
                    send_pair(pick_sample(), pick_sample(), j == len - 1, 1'b0, '0);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        wait (stats_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pss_pkg.sv
hw/rtl/pss_div.sv
hw/rtl/pss_ctrl.sv
hw/rtl/pss_dp.sv
hw/rtl/paired_sample_statistics_unit.sv
hw/rtl/pss_checker.sv
tb/sv/tb.sv
